// ===== src/ftach_pkg.sv =====
package ftach_pkg;

  // Field widths of the channels.
  localparam int unsigned DUTY_W     = 24;
  localparam int unsigned MINW_W     = 16;
  localparam int unsigned RPM_W      = 25;
  localparam int unsigned CMP_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned TIME_W     = 32;

  // Speed numerator: microseconds per half minute (each tach edge marks half a turn).
  localparam logic [RPM_W-1:0] RPM_SCALE = RPM_W'(30000000);

  // Register reset values.
  localparam logic [DUTY_W-1:0] MAX_PWM_RST  = DUTY_W'(255);
  localparam logic [MINW_W-1:0] MIN_WAIT_RST = MINW_W'(1000);

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_PWM_PERIOD   = 320;
  localparam int unsigned DEF_TICKS_PER_MS = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PWM  = 1'b0,
    CFG_MIN_WAIT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_DUTY = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_MUL,
    ST_PICK,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    TGT_FAN0,
    TGT_FAN1,
    TGT_DUTY
  } div_tgt_e;

endpackage

// ===== src/ftach_if.sv =====
// Input beat: one microsecond tick with edge flags, or a duty request.
interface ftach_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic                           edge_zero;
  logic                           edge_one;
  logic                           channel;
  logic [ftach_pkg::DUTY_W-1:0]   duty_value;

  modport source (output valid, func, edge_zero, edge_one, channel, duty_value,
                  input ready);
  modport sink   (input valid, func, edge_zero, edge_one, channel, duty_value,
                  output ready);
endinterface

// Result beat: speeds, running flags and compare values of both fans.
interface ftach_out_if;
  logic                          valid;
  logic                          ready;
  logic [ftach_pkg::RPM_W-1:0]   rpm_zero;
  logic [ftach_pkg::RPM_W-1:0]   rpm_one;
  logic                          running_zero;
  logic                          running_one;
  logic [ftach_pkg::CMP_W-1:0]   compare_zero;
  logic [ftach_pkg::CMP_W-1:0]   compare_one;

  modport source (output valid, rpm_zero, rpm_one, running_zero, running_one,
                  compare_zero, compare_one, input ready);
  modport sink   (input valid, rpm_zero, rpm_one, running_zero, running_one,
                  compare_zero, compare_one, output ready);
endinterface

// Configuration write beat.
interface ftach_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ftach_pkg::CFG_IDX_W-1:0]    index;
  logic [ftach_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/fan_tach_rpm_pwm_monitor_unit.sv =====
// Two-fan tachometer and PWM duty monitor. Each input beat is either one
// microsecond tick carrying the rising-edge flags of both tach inputs, or a
// duty request for one fan; every beat returns exactly one result beat with
// both speeds (30000000 / edge period in microseconds, 0 for a zero period),
// both running flags and both PWM compare values (PWM_PERIOD * duty /
// max_pwm, duty clamped to max_pwm). All quotients come from one shared
// restoring divider that retires one quotient bit per cycle over
// DIV_W = max(25, clog2(PWM_PERIOD+1) + 24) steps (33 at the defaults).
// A tick runs the window checks and then one division for each fan that has
// an edge and a nonzero period; a duty request runs the multiply and then
// one division unless max_pwm is zero. The block takes one beat at a time;
// the result sits in an output register, so a stalled sink holds the next
// beat only in its finishing step. Configuration writes are always taken
// and are expected only while the block is idle.
module fan_tach_rpm_pwm_monitor_unit #(
  parameter int unsigned PWM_PERIOD   = ftach_pkg::DEF_PWM_PERIOD,
  parameter int unsigned TICKS_PER_MS = ftach_pkg::DEF_TICKS_PER_MS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftach_in_if.sink    in_i,
  ftach_out_if.source out_o,
  ftach_cfg_if.sink   cfg_i
);

  localparam int unsigned TIME_W = ftach_pkg::TIME_W;
  localparam int unsigned RPM_W  = ftach_pkg::RPM_W;
  localparam int unsigned CMP_W  = ftach_pkg::CMP_W;
  localparam int unsigned DUTY_W = ftach_pkg::DUTY_W;
  localparam int unsigned MINW_W = ftach_pkg::MINW_W;
  localparam int unsigned PRE_W  = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam int unsigned PWM_W  = $clog2(PWM_PERIOD + 1);
  localparam int unsigned PROD_W = PWM_W + DUTY_W;
  localparam int unsigned DIV_W  = (PROD_W > RPM_W) ? PROD_W : RPM_W;
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);

  localparam logic [PRE_W-1:0] PRE_LAST  = PRE_W'(TICKS_PER_MS - 1);
  localparam logic [PWM_W-1:0] PWM_CONST = PWM_W'(PWM_PERIOD);

  localparam int unsigned PEND_DUTY = 2;

  // Sequencer state.
  ftach_pkg::state_e   state_q, state_d;
  ftach_pkg::div_tgt_e tgt_q;
  logic [2:0]          pend_q;

  // Configuration registers.
  logic [DUTY_W-1:0] max_pwm_q;
  logic [MINW_W-1:0] min_wait_q;

  // Time base.
  logic [TIME_W-1:0] usec_q;
  logic [PRE_W-1:0]  prescale_q;
  logic [TIME_W-1:0] msec_q;

  // Per-fan state.
  logic [TIME_W-1:0] time_now_q  [2];
  logic [TIME_W-1:0] period_q    [2];
  logic [TIME_W-1:0] count_q     [2];
  logic [TIME_W-1:0] snapshot_q  [2];
  logic [TIME_W-1:0] win_start_q [2];
  logic              running_q   [2];
  logic [RPM_W-1:0]  rpm_q       [2];
  logic [CMP_W-1:0]  cmp_q       [2];

  // Duty request working registers.
  logic              chan_q;
  logic [DUTY_W-1:0] duty_q;
  logic [PROD_W-1:0] prod_q;

  // Shared divider.
  logic [DIV_W-1:0]  dq_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] dvsr_q;
  logic [CNT_W-1:0]  cnt_q;

  // Output register.
  logic              out_valid_q;
  logic [RPM_W-1:0]  out_rpm_q  [2];
  logic              out_run_q  [2];
  logic [CMP_W-1:0]  out_cmp_q  [2];

  logic              in_fire;
  logic              out_free;
  logic [TIME_W-1:0] usec_nx;
  logic [1:0]        edge_v;
  logic              pick_fan0;
  logic              pick_fan1;
  logic              pick_duty;
  logic              div_go;
  logic [TIME_W:0]   trial;
  logic              trial_ge;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign usec_nx  = usec_q + TIME_W'(1);
  assign edge_v   = {in_i.edge_one, in_i.edge_zero};

  // Pending work is served fan 0 first, then fan 1, then the duty request.
  assign pick_fan0 = pend_q[0];
  assign pick_fan1 = !pend_q[0] && pend_q[1];
  assign pick_duty = (pend_q == 3'b100);
  assign div_go    = (pick_fan0 && (period_q[0] != '0)) ||
                     (pick_fan1 && (period_q[1] != '0)) ||
                     (pick_duty && (max_pwm_q != '0));

  // One restoring division step.
  assign trial    = {rem_q, dq_q[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, dvsr_q});

  assign in_i.ready    = (state_q == ftach_pkg::ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.rpm_zero     = out_rpm_q[0];
  assign out_o.rpm_one      = out_rpm_q[1];
  assign out_o.running_zero = out_run_q[0];
  assign out_o.running_one  = out_run_q[1];
  assign out_o.compare_zero = out_cmp_q[0];
  assign out_o.compare_one  = out_cmp_q[1];

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftach_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ftach_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (ftach_pkg::func_e'(in_i.func) == ftach_pkg::FUNC_TICK) begin
            state_d = ftach_pkg::ST_WINDOW;
          end else begin
            state_d = ftach_pkg::ST_MUL;
          end
        end
      end
      ftach_pkg::ST_WINDOW: state_d = ftach_pkg::ST_PICK;
      ftach_pkg::ST_MUL:    state_d = ftach_pkg::ST_PICK;
      ftach_pkg::ST_PICK: begin
        if (pend_q == '0) begin
          state_d = ftach_pkg::ST_DONE;
        end else if (div_go) begin
          state_d = ftach_pkg::ST_DIV;
        end
      end
      ftach_pkg::ST_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ftach_pkg::ST_STORE;
        end
      end
      ftach_pkg::ST_STORE: state_d = ftach_pkg::ST_PICK;
      ftach_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ftach_pkg::ST_IDLE;
        end
      end
      default: state_d = ftach_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pwm_q  <= ftach_pkg::MAX_PWM_RST;
      min_wait_q <= ftach_pkg::MIN_WAIT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (ftach_pkg::cfg_reg_e'(cfg_i.index))
        ftach_pkg::CFG_MAX_PWM:  max_pwm_q  <= cfg_i.data;
        ftach_pkg::CFG_MIN_WAIT: min_wait_q <= cfg_i.data[MINW_W-1:0];
        default: ;
      endcase
    end
  end

  // Time base, edge capture, window checks and result storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usec_q     <= '0;
      prescale_q <= '0;
      msec_q     <= '0;
      pend_q     <= '0;
      tgt_q      <= ftach_pkg::TGT_FAN0;
      chan_q     <= 1'b0;
      for (int f = 0; f < 2; f++) begin
        time_now_q[f]  <= '0;
        period_q[f]    <= '0;
        count_q[f]     <= '0;
        snapshot_q[f]  <= '0;
        win_start_q[f] <= '0;
        running_q[f]   <= 1'b0;
        rpm_q[f]       <= '0;
        cmp_q[f]       <= '0;
      end
    end else begin
      case (state_q)
        ftach_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (ftach_pkg::func_e'(in_i.func) == ftach_pkg::FUNC_TICK) begin
              usec_q <= usec_nx;
              if (prescale_q == PRE_LAST) begin
                prescale_q <= '0;
                msec_q     <= msec_q + TIME_W'(1);
              end else begin
                prescale_q <= prescale_q + PRE_W'(1);
              end
              for (int f = 0; f < 2; f++) begin
                if (edge_v[f]) begin
                  period_q[f]   <= usec_nx - time_now_q[f];
                  time_now_q[f] <= usec_nx;
                  count_q[f]    <= count_q[f] + TIME_W'(1);
                end
              end
              pend_q <= {1'b0, edge_v};
            end else begin
              chan_q <= in_i.channel;
              pend_q <= 3'b100;
            end
          end
        end
        ftach_pkg::ST_WINDOW: begin
          // A start ahead of the clock (after wrap) is pulled back first.
          for (int f = 0; f < 2; f++) begin
            if (msec_q < win_start_q[f]) begin
              win_start_q[f] <= msec_q;
              if (min_wait_q == '0) begin
                if (count_q[f] == snapshot_q[f]) begin
                  running_q[f] <= 1'b0;
                end else begin
                  snapshot_q[f] <= count_q[f];
                  running_q[f]  <= 1'b1;
                end
              end
            end else if ((msec_q - win_start_q[f]) >= TIME_W'(min_wait_q)) begin
              win_start_q[f] <= msec_q;
              if (count_q[f] == snapshot_q[f]) begin
                running_q[f] <= 1'b0;
              end else begin
                snapshot_q[f] <= count_q[f];
                running_q[f]  <= 1'b1;
              end
            end
          end
        end
        ftach_pkg::ST_PICK: begin
          // Zero divisors resolve at once; everything else goes to the divider.
          if (pick_fan0) begin
            tgt_q <= ftach_pkg::TGT_FAN0;
            if (period_q[0] == '0) begin
              rpm_q[0]  <= '0;
              pend_q[0] <= 1'b0;
            end
          end else if (pick_fan1) begin
            tgt_q <= ftach_pkg::TGT_FAN1;
            if (period_q[1] == '0) begin
              rpm_q[1]  <= '0;
              pend_q[1] <= 1'b0;
            end
          end else if (pick_duty) begin
            tgt_q <= ftach_pkg::TGT_DUTY;
            if (max_pwm_q == '0) begin
              cmp_q[chan_q]     <= '0;
              pend_q[PEND_DUTY] <= 1'b0;
            end
          end
        end
        ftach_pkg::ST_STORE: begin
          case (tgt_q)
            ftach_pkg::TGT_FAN0: begin
              rpm_q[0]  <= dq_q[RPM_W-1:0];
              pend_q[0] <= 1'b0;
            end
            ftach_pkg::TGT_FAN1: begin
              rpm_q[1]  <= dq_q[RPM_W-1:0];
              pend_q[1] <= 1'b0;
            end
            ftach_pkg::TGT_DUTY: begin
              cmp_q[chan_q]     <= dq_q[CMP_W-1:0];
              pend_q[PEND_DUTY] <= 1'b0;
            end
            default: pend_q <= '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Duty clamp, scaling multiply and the shared divider datapath.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      duty_q <= (in_i.duty_value > max_pwm_q) ? max_pwm_q : in_i.duty_value;
    end
    if (state_q == ftach_pkg::ST_MUL) begin
      prod_q <= PROD_W'(PWM_CONST) * PROD_W'(duty_q);
    end
    if ((state_q == ftach_pkg::ST_PICK) && div_go) begin
      rem_q <= '0;
      cnt_q <= CNT_W'(DIV_W);
      if (pick_fan0) begin
        dq_q   <= DIV_W'(ftach_pkg::RPM_SCALE);
        dvsr_q <= period_q[0];
      end else if (pick_fan1) begin
        dq_q   <= DIV_W'(ftach_pkg::RPM_SCALE);
        dvsr_q <= period_q[1];
      end else begin
        dq_q   <= DIV_W'(prod_q);
        dvsr_q <= TIME_W'(max_pwm_q);
      end
    end else if (state_q == ftach_pkg::ST_DIV) begin
      rem_q <= trial_ge ? TIME_W'(trial - {1'b0, dvsr_q}) : trial[TIME_W-1:0];
      dq_q  <= {dq_q[DIV_W-2:0], trial_ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ftach_pkg::ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ftach_pkg::ST_DONE) && out_free) begin
      for (int f = 0; f < 2; f++) begin
        out_rpm_q[f] <= rpm_q[f];
        out_run_q[f] <= running_q[f];
        out_cmp_q[f] <= cmp_q[f];
      end
    end
  end

  // The block holds off new beats while one is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input accepted twice in a row");

  // A result appears only as the sequencer finishes a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == ftach_pkg::ST_DONE))
    else $error("result raised outside the finishing step");

  // Every queued division or zero case is served before the result goes out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ftach_pkg::ST_DONE) |-> (pend_q == '0))
    else $error("result formed with work still pending");

  // A quotient is stored only after the divider has run its full count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ftach_pkg::ST_STORE) |->
      ($past(state_q) == ftach_pkg::ST_DIV) && ($past(cnt_q) == CNT_W'(1)))
    else $error("quotient stored before division finished");

endmodule

// ===== tb/ftach_monitor_checker.sv =====
// Watches the tick, result and register channels of the fan monitor. It keeps
// its own copy of the fan state, predicts the status beat that each accepted
// input beat must return, and compares every result beat with the oldest
// prediction that is still waiting.
module ftach_monitor_checker
  import ftach_pkg::*;
#(
  parameter int unsigned PWM_PERIOD   = DEF_PWM_PERIOD,
  parameter int unsigned TICKS_PER_MS = DEF_TICKS_PER_MS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftach_in_if         in_i,
  ftach_out_if        out_i,
  ftach_cfg_if        cfg_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic [RPM_W-1:0] rpm_zero;
    logic [RPM_W-1:0] rpm_one;
    logic             running_zero;
    logic             running_one;
    logic [CMP_W-1:0] compare_zero;
    logic [CMP_W-1:0] compare_one;
  } fan_status_t;

  // Register copies.
  logic [DUTY_W-1:0] max_pwm_q;
  logic [MINW_W-1:0] min_wait_q;

  // Time base and per-fan state.
  logic [TIME_W-1:0] usec_q;
  logic [TIME_W-1:0] msec_q;
  int unsigned       prescale_q;
  logic [TIME_W-1:0] stamp_now   [2];
  logic [TIME_W-1:0] stamp_prev  [2];
  logic [TIME_W-1:0] edges_seen  [2];
  logic [TIME_W-1:0] edges_snap  [2];
  logic [TIME_W-1:0] window_from [2];
  logic              fan_running [2];
  logic [TIME_W-1:0] duty_cmp    [2];

  fan_status_t pending_status_q[$];
  fan_status_t oldest_status;
  int unsigned mismatch_cnt;

  function automatic void clear_fan_state();
    max_pwm_q  = MAX_PWM_RST;
    min_wait_q = MIN_WAIT_RST;
    usec_q     = '0;
    msec_q     = '0;
    prescale_q = 0;
    for (int f = 0; f < 2; f++) begin
      stamp_now[f]   = '0;
      stamp_prev[f]  = '0;
      edges_seen[f]  = '0;
      edges_snap[f]  = '0;
      window_from[f] = '0;
      fan_running[f] = 1'b0;
      duty_cmp[f]    = '0;
    end
  endfunction

  // Speed from the latest edge period; a zero period reads as standstill.
  function automatic logic [RPM_W-1:0] speed_of(int fan);
    logic [TIME_W-1:0] period;
    period = stamp_now[fan] - stamp_prev[fan];
    if (period == '0) begin
      return '0;
    end
    return RPM_W'(TIME_W'(RPM_SCALE) / period);
  endfunction

  function automatic void stamp_edge(int fan);
    edges_seen[fan] = edges_seen[fan] + 1;
    stamp_prev[fan] = stamp_now[fan];
    stamp_now[fan]  = usec_q;
  endfunction

  // A window that has lasted min_wait_ms closes and decides the running flag.
  function automatic void close_window(int fan);
    if (msec_q < window_from[fan]) begin
      window_from[fan] = msec_q;
    end
    if (msec_q - window_from[fan] >= TIME_W'(min_wait_q)) begin
      window_from[fan] = msec_q;
      if (edges_seen[fan] == edges_snap[fan]) begin
        fan_running[fan] = 1'b0;
      end else begin
        edges_snap[fan]  = edges_seen[fan];
        fan_running[fan] = 1'b1;
      end
    end
  endfunction

  function automatic void set_duty(int fan, logic [DUTY_W-1:0] duty);
    logic [63:0] clamped;
    if (max_pwm_q == '0) begin
      duty_cmp[fan] = '0;
    end else begin
      clamped = (duty > max_pwm_q) ? 64'(max_pwm_q) : 64'(duty);
      duty_cmp[fan] = TIME_W'((64'(PWM_PERIOD) * clamped) / 64'(max_pwm_q));
    end
  endfunction

  // Applies one input beat to the fan state and returns the status after it.
  function automatic fan_status_t next_fan_status(logic func, logic edge_zero,
                                                  logic edge_one, logic channel,
                                                  logic [DUTY_W-1:0] duty);
    fan_status_t status;
    if (func_e'(func) == FUNC_TICK) begin
      usec_q     = usec_q + 1;
      prescale_q = prescale_q + 1;
      if (prescale_q >= TICKS_PER_MS) begin
        prescale_q = 0;
        msec_q     = msec_q + 1;
      end
      if (edge_zero) begin
        stamp_edge(0);
      end
      if (edge_one) begin
        stamp_edge(1);
      end
      close_window(0);
      close_window(1);
    end else begin
      set_duty(int'(channel), duty);
    end
    status.rpm_zero     = speed_of(0);
    status.rpm_one      = speed_of(1);
    status.running_zero = fan_running[0];
    status.running_one  = fan_running[1];
    status.compare_zero = duty_cmp[0][CMP_W-1:0];
    status.compare_one  = duty_cmp[1][CMP_W-1:0];
    return status;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Result beats are retired before new input beats are predicted; the block
  // holds one beat at a time, so a result never belongs to a same-edge input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_fan_state();
      pending_status_q.delete();
      mismatch_cnt = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (pending_status_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result beat expected none, got rpm %0d/%0d", $time,
                   out_i.rpm_zero, out_i.rpm_one);
        end else begin
          oldest_status = pending_status_q.pop_front();
          check_field("rpm_zero", 32'(oldest_status.rpm_zero), 32'(out_i.rpm_zero));
          check_field("rpm_one", 32'(oldest_status.rpm_one), 32'(out_i.rpm_one));
          check_field("running_zero", 32'(oldest_status.running_zero),
                      32'(out_i.running_zero));
          check_field("running_one", 32'(oldest_status.running_one),
                      32'(out_i.running_one));
          check_field("compare_zero", 32'(oldest_status.compare_zero),
                      32'(out_i.compare_zero));
          check_field("compare_one", 32'(oldest_status.compare_one),
                      32'(out_i.compare_one));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_MAX_PWM: begin
            max_pwm_q = cfg_i.data[DUTY_W-1:0];
          end
          CFG_MIN_WAIT: begin
            min_wait_q = cfg_i.data[MINW_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        pending_status_q.push_back(next_fan_status(in_i.func, in_i.edge_zero,
                                                   in_i.edge_one, in_i.channel,
                                                   in_i.duty_value));
      end
    end
    mismatches_o  <= mismatch_cnt;
    outstanding_o <= pending_status_q.size();
  end

endmodule

// ===== tb/tb_fan_tach_rpm_pwm_monitor_unit.sv =====
module tb_fan_tach_rpm_pwm_monitor_unit;
  import ftach_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned TAIL_CYCLES     = 100;
  localparam int unsigned CFG_SETTLE      = 8;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BEATS_PER_PHASE = 228;
  localparam int unsigned MAX_IDLE        = 16;
  localparam int unsigned DUTY_PCT        = 15;

  logic clk_i;
  logic rst_ni;

  ftach_in_if  in_if();
  ftach_out_if out_if();
  ftach_cfg_if cfg_if();

  int unsigned mismatches;
  int unsigned outstanding;

  // Full scale last written, used to aim duty requests at the clamp.
  logic [DUTY_W-1:0] max_pwm_set;

  bit source_eager;
  bit sink_eager;
  bit hold_req;

  int unsigned tick_beats;
  int unsigned duty_beats;
  int unsigned edge_flags;
  int unsigned cfg_writes;

  fan_tach_rpm_pwm_monitor_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  ftach_monitor_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_if),
    .out_i         (out_if),
    .cfg_i         (cfg_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one input beat after a random gap and waits until it is taken.
  // Valid stays high after the beat so that back-to-back beats need no toggle.
  task automatic send_beat(func_e func, bit edge_zero, bit edge_one, bit channel,
                           logic [DUTY_W-1:0] duty);
    int unsigned gap;
    gap = source_eager ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.func       <= func;
    in_if.edge_zero  <= edge_zero;
    in_if.edge_one   <= edge_one;
    in_if.channel    <= channel;
    in_if.duty_value <= duty;
    in_if.valid      <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    if (func == FUNC_TICK) begin
      tick_beats++;
      edge_flags += int'(edge_zero) + int'(edge_one);
    end else begin
      duty_beats++;
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_results_drained();
    if (in_if.valid) begin
      in_if.valid <= 1'b0;
    end
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    wait_results_drained();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_MAX_PWM) begin
      max_pwm_set = data[DUTY_W-1:0];
    end
    cfg_writes++;
  endtask

  // Mostly ticks with edges at the given rate; duty requests hit zero, full
  // scale, the clamp region, the legal range and the whole field.
  task automatic random_beat(int unsigned edge_pct);
    logic [DUTY_W-1:0] duty;
    bit                edge_zero;
    bit                edge_one;
    edge_zero = ($urandom_range(0, 99) < edge_pct);
    edge_one  = ($urandom_range(0, 99) < edge_pct);
    if ($urandom_range(0, 99) < DUTY_PCT) begin
      case ($urandom_range(0, 4))
        0: duty = '0;
        1: duty = max_pwm_set;
        2: duty = (max_pwm_set == '1) ? '1 :
                  DUTY_W'($urandom_range(32'(max_pwm_set) + 1, 32'hFF_FFFF));
        3: duty = DUTY_W'($urandom_range(0, 32'(max_pwm_set)));
        default: duty = DUTY_W'($urandom);
      endcase
      send_beat(FUNC_DUTY, edge_zero, edge_one, 1'($urandom), duty);
    end else begin
      send_beat(FUNC_TICK, edge_zero, edge_one, 1'($urandom), DUTY_W'($urandom));
    end
  endtask

  // Result side: a random stall before each beat, and one long hold on request.
  initial begin : sink_side
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_eager ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timed out after %0d cycles without a beat", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [DUTY_W-1:0] phase_max;
    logic [MINW_W-1:0] phase_wait;
    int unsigned       phase_pct;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_TICK;
    in_if.edge_zero  = 1'b0;
    in_if.edge_one   = 1'b0;
    in_if.channel    = 1'b0;
    in_if.duty_value = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_MAX_PWM;
    cfg_if.data      = '0;
    source_eager     = 1'b0;
    sink_eager       = 1'b0;
    hold_req         = 1'b0;
    max_pwm_set      = MAX_PWM_RST;
    tick_beats       = 0;
    duty_beats       = 0;
    edge_flags       = 0;
    cfg_writes       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: standstill, single edges, the one-microsecond period,
    // both fans at once, and fields that the operation must ignore.
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b1, 1'b0, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b1, 1'b0, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b1, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b1, 1'b1, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b1, '1);
    send_beat(FUNC_DUTY, 1'b1, 1'b1, 1'b0, '0);
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b1, '1);
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b0, DUTY_W'(255));
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b1, DUTY_W'(128));

    // A zero full scale always gives a zero compare value.
    write_register(CFG_MAX_PWM, '0);
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b0, DUTY_W'(77));

    // Smallest and largest full scale, with clamping above it.
    write_register(CFG_MAX_PWM, CFG_DATA_W'(1));
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b1, '0);
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b1, DUTY_W'(1));
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b0, DUTY_W'(3));
    write_register(CFG_MAX_PWM, '1);
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b0, '1);
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b1, DUTY_W'(1));
    send_beat(FUNC_DUTY, 1'b0, 1'b0, 1'b1, DUTY_W'(24'h80_0000));

    // A zero window closes on every tick; the widest one never closes here.
    write_register(CFG_MIN_WAIT, '0);
    send_beat(FUNC_TICK, 1'b1, 1'b0, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b1, 1'b1, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b1, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
    write_register(CFG_MIN_WAIT, CFG_DATA_W'(16'hFFFF));
    send_beat(FUNC_TICK, 1'b1, 1'b1, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);

    // Random phases, each with its own registers, edge rate and idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          phase_max = MAX_PWM_RST; phase_wait = '0; phase_pct = 30;
        end
        1: begin
          phase_max = DUTY_W'(1); phase_wait = MINW_W'(1); phase_pct = 5;
        end
        2: begin
          phase_max = '1; phase_wait = '0; phase_pct = 60;
        end
        3: begin
          phase_max = DUTY_W'($urandom_range(1, 32'hFF_FFFF));
          phase_wait = MINW_W'(2); phase_pct = 3;
        end
        4: begin
          phase_max = '0; phase_wait = '1; phase_pct = 20;
        end
        5: begin
          phase_max = DUTY_W'($urandom_range(1, 32'hFF_FFFF));
          phase_wait = MINW_W'($urandom); phase_pct = 10;
        end
        6: begin
          phase_max = DUTY_W'(24'h80_0000); phase_wait = '0; phase_pct = 90;
        end
        default: begin
          phase_max = MAX_PWM_RST; phase_wait = MINW_W'(1); phase_pct = 15;
        end
      endcase
      write_register(CFG_MAX_PWM, CFG_DATA_W'(phase_max));
      write_register(CFG_MIN_WAIT, CFG_DATA_W'(phase_wait));
      source_eager = (p == 1 || p == 4);
      sink_eager   = (p == 4 || p == 6);
      // The result side holds off while the source keeps offering beats.
      if (p == 1) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (p == 3 && n == BEATS_PER_PHASE / 2) begin
          wait_results_drained();
        end
        random_beat(phase_pct);
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d tick beats carrying %0d edge flags and %0d duty beats,",
             tick_beats, edge_flags, duty_beats);
    $display("with %0d register writes across directed and %0d random settings.",
             cfg_writes, RANDOM_PHASES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ftach_pkg.sv
src/ftach_if.sv
src/fan_tach_rpm_pwm_monitor_unit.sv
tb/ftach_monitor_checker.sv
tb/tb_fan_tach_rpm_pwm_monitor_unit.sv
